/* rtl/assert_macros.svh */
// assertion macros included by bisection_root_finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/brf_pkg.sv */
// types and constants of the bisection root finder
package brf_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 31;
  localparam int ITER_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_EVAL  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_VALUE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ACC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ACC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IT = 2'd2;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] x_lower;
    logic signed [DATA_W-1:0] x_upper;
    logic signed [DATA_W-1:0] f_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] point;
    logic [1:0]               kind;
    logic [ITER_W-1:0]        iterations;
  } out_item_t;

endpackage

/* rtl/bisection_root_finder.sv */
// bisection root finder controller, signed Q16.16
//
// Input channel (in_valid/in_ready/in_data): a word with cmd start carries
// the bracket x_lower..x_upper; a word with cmd value carries f at the point
// the block last asked for. Every input word gives exactly one result word on
// the out channel (out_valid/out_ready/out_data): kind eval asks the user to
// evaluate f at point, kind done gives the root estimate, kind error answers
// a value word sent while no search runs.
// The result is loaded into the output register at the edge that takes the
// input word. Throughput is one word per cycle while out_ready is high, set by the
// single output register; in_ready stays high while that register is empty
// or being emptied, so a stalled receiver holds back at most one result.
// The real pace of a search is set by the outside evaluation of f.
// Config (cfg_we/cfg_index/cfg_wdata): x accuracy, y accuracy, iteration
// limit, to be written by the user only while idle; the block does not enforce
// this. Synchronous reset (rst_n low) holds in_ready low, empties the output
// register, drops any search and loads 66, 66 and 50 into the config.
// A start word during a running search abandons it and begins a new one.
module bisection_root_finder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  brf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output brf_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [brf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brf_pkg::ACC_W-1:0]         cfg_wdata
);
  import brf_pkg::*;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_WAIT_LOW = 2'd1;
  localparam logic [1:0] PH_WAIT_MID = 2'd2;

  localparam logic [DATA_W-1:0] ABS_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic [ACC_W-1:0]  x_acc_r, y_acc_r;
  logic [ITER_W-1:0] max_it_r;

  logic [1:0]        phase_r, phase_nxt;
  logic [DATA_W-1:0] low_end_r, low_end_nxt;
  logic [DATA_W-1:0] high_end_r, high_end_nxt;
  logic [DATA_W-1:0] low_value_r, low_value_nxt;
  logic [DATA_W-1:0] best_abs_r, best_abs_nxt;
  logic [DATA_W-1:0] best_point_r, best_point_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  logic              out_valid_r;
  out_item_t         out_data_r, res_nxt;
  logic              in_acc;

  logic [DATA_W-1:0] mid;
  logic [DATA_W-1:0] f_abs;
  logic              opposite;

  // floor((a+b)/2) on signed values, with one extra sum bit
  function automatic logic [DATA_W-1:0] mid_of(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return s[DATA_W:1];
  endfunction

  // limit check, width check, then answer or request the midpoint
  function automatic out_item_t loop_head(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                                          logic [ITER_W-1:0] its, logic [DATA_W-1:0] bp);
    logic [DATA_W-1:0] diff;
    logic              narrow;
    out_item_t         r;
    diff   = hi - lo;
    narrow = ($signed(hi) < $signed(lo)) || (diff < {1'b0, x_acc_r});
    r.iterations = its;
    if (its >= max_it_r) begin
      r.point = bp;
      r.kind  = KIND_DONE;
    end else if (narrow) begin
      r.point = mid_of(lo, hi);
      r.kind  = KIND_DONE;
    end else begin
      r.point = mid_of(lo, hi);
      r.kind  = KIND_EVAL;
    end
    return r;
  endfunction

  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mid      = mid_of(low_end_r, high_end_r);
  assign f_abs    = in_data.f_value[DATA_W-1] ? (~in_data.f_value + 1'b1) : in_data.f_value;
  // sign test in place of the product low_value * f <= 0
  assign opposite = (in_data.f_value == '0) || (low_value_r == '0) ||
                    (in_data.f_value[DATA_W-1] != low_value_r[DATA_W-1]);

  always_comb begin
    phase_nxt      = phase_r;
    low_end_nxt    = low_end_r;
    high_end_nxt   = high_end_r;
    low_value_nxt  = low_value_r;
    best_abs_nxt   = best_abs_r;
    best_point_nxt = best_point_r;
    iter_nxt       = iter_r;
    res_nxt        = '{point: '0, kind: KIND_ERROR, iterations: '0};
    if (in_data.cmd == CMD_START) begin
      low_end_nxt    = in_data.x_lower;
      high_end_nxt   = in_data.x_upper;
      low_value_nxt  = '0;
      best_abs_nxt   = ABS_MAX;
      best_point_nxt = mid_of(in_data.x_lower, in_data.x_upper);
      iter_nxt       = '0;
      phase_nxt      = PH_WAIT_LOW;
      res_nxt        = '{point: in_data.x_lower, kind: KIND_EVAL, iterations: '0};
    end else begin
      unique case (phase_r)
        PH_WAIT_LOW: begin
          low_value_nxt = in_data.f_value;
          res_nxt       = loop_head(low_end_r, high_end_r, iter_r, best_point_r);
          phase_nxt     = (res_nxt.kind == KIND_EVAL) ? PH_WAIT_MID : PH_IDLE;
        end
        PH_WAIT_MID: begin
          if (f_abs < best_abs_r) begin
            best_abs_nxt   = f_abs;
            best_point_nxt = mid;
          end
          if (f_abs < {1'b0, y_acc_r}) begin
            res_nxt   = '{point: mid, kind: KIND_DONE, iterations: iter_r};
            phase_nxt = PH_IDLE;
          end else begin
            if (opposite) begin
              high_end_nxt = mid;
            end else begin
              low_end_nxt   = mid;
              low_value_nxt = in_data.f_value;
            end
            iter_nxt  = iter_r + 1'b1;
            res_nxt   = loop_head(low_end_nxt, high_end_nxt, iter_nxt, best_point_nxt);
            phase_nxt = (res_nxt.kind == KIND_EVAL) ? PH_WAIT_MID : PH_IDLE;
          end
        end
        default: begin
          // value word with no search running: error, state untouched
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r      <= ACC_W'(66);
      y_acc_r      <= ACC_W'(66);
      max_it_r     <= ITER_W'(50);
      phase_r      <= PH_IDLE;
      low_end_r    <= '0;
      high_end_r   <= '0;
      low_value_r  <= '0;
      best_abs_r   <= ABS_MAX;
      best_point_r <= '0;
      iter_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_X_ACC:  x_acc_r  <= cfg_wdata;
          CFG_Y_ACC:  y_acc_r  <= cfg_wdata;
          CFG_MAX_IT: max_it_r <= cfg_wdata[ITER_W-1:0];
          default:    max_it_r <= max_it_r;
        endcase
      end
      if (in_acc) begin
        phase_r      <= phase_nxt;
        low_end_r    <= low_end_nxt;
        high_end_r   <= high_end_nxt;
        low_value_r  <= low_value_nxt;
        best_abs_r   <= best_abs_nxt;
        best_point_r <= best_point_nxt;
        iter_r       <= iter_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_idle_value_keeps_idle, clk, rst_n, (in_acc && in_data.cmd == CMD_VALUE && phase_r == PH_IDLE) |=> (phase_r == PH_IDLE), "value word while idle left idle state")
  `ASSERT_CLK(a_start_asks_lower, clk, rst_n, (in_acc && in_data.cmd == CMD_START) |=> (out_valid_r && out_data_r.kind == KIND_EVAL && out_data_r.point == $past(in_data.x_lower)), "start did not request f at lower bound")
  `ASSERT_CLK(a_eval_iff_busy, clk, rst_n, in_acc |=> ((out_data_r.kind == KIND_EVAL) == (phase_r != PH_IDLE)), "result kind disagrees with search phase")

endmodule
